### rtl/knn_pkg.sv
// Shared widths, defaults and queue entry types for the k-nearest-neighbour selector.
package knn_pkg;

   localparam int IDX_W = 12;
   localparam int DIST_W = 24;
   localparam int NUCLEI_W = 17;
   localparam int MAX_NEIGHBOURS_DEF = 16;
   localparam int MAX_NUCLEI_DEF = 4096;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [IDX_W-1:0]  idx;
      logic              keep;
      logic              last;
      logic [IDX_W-1:0]  query;
   } knn_cand_type;

   typedef struct packed {
      logic         valid;
      knn_cand_type cand;
   } knn_queue_type;

endpackage

### rtl/knn_if.sv
// Request and result channel interfaces of the k-nearest-neighbour selector.
interface knn_req_if
   import knn_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  query_index;
   logic [IDX_W-1:0]  candidate_index;
   logic [DIST_W-1:0] separation;
   logic signed [DIST_W-1:0] query_shift;
   logic signed [DIST_W-1:0] candidate_shift;
   logic              final_candidate;

   modport source (output valid, query_index, candidate_index, separation, query_shift,
                   candidate_shift, final_candidate, input ready);
   modport sink (input valid, query_index, candidate_index, separation, query_shift,
                 candidate_shift, final_candidate, output ready);
endinterface

interface knn_rsp_if
   import knn_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] neighbour_index;
   logic             neighbour_valid;
   logic             final_result;

   modport source (output valid, neighbour_index, neighbour_valid, final_result, input ready);
   modport sink (input valid, neighbour_index, neighbour_valid, final_result, output ready);
endinterface

### rtl/k_nearest_neighbour_select.sv
// Top level of the k-nearest-neighbour selector: front end, queue and back end.
//
//   Channel   Direction  Handshake                 Contents
//   req_bus   in         valid/ready               one candidate of a query run
//   rsp_bus   out        valid/ready               one selected neighbour index
//   csr_*     in         write enable, no wait     shift_mode register
//
// During a run one request is taken per cycle while the queue has room; the
// insertion list compares all kept entries at once and the four-entry queue
// absorbs back-end pauses. After the final request the back end gathers the
// qualifying indices in order, then emits each one through the output register.
// Reset is synchronous and clears the list, the queue and the register.
// Either side may stall at any time; the output register holds a result until taken.
module k_nearest_neighbour_select
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
   parameter int MAX_NUCLEI = MAX_NUCLEI_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_enable,
   input  logic      csr_write_data,
   knn_req_if.sink   req_bus,
   knn_rsp_if.source rsp_bus
);

   knn_queue_type queue_head;
   logic          queue_pop;

   knn_front #(
      .MAX_NUCLEI(MAX_NUCLEI)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_bus(req_bus),
      .queue_head(queue_head),
      .queue_pop(queue_pop)
   );

   knn_back #(
      .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .queue_head(queue_head),
      .queue_pop(queue_pop),
      .rsp_bus(rsp_bus)
   );

endmodule

### rtl/knn_front.sv
// Front end: register, distance computation, candidate filtering and a short queue.
module knn_front
   import knn_pkg::*;
#(
   parameter int MAX_NUCLEI = MAX_NUCLEI_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic          csr_write_data,
   knn_req_if.sink       req_bus,
   output knn_queue_type queue_head,
   input  logic          queue_pop
);

   localparam int QPW = $clog2(QUEUE_DEPTH);

   logic                 shift_mode_ff;
   knn_cand_type         mem_ff [QUEUE_DEPTH];
   logic [QPW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]         count_ff, count_in;
   logic signed [DIST_W:0] diff;
   logic [DIST_W:0]      diff_abs;
   knn_cand_type         cand;
   logic                 push;
   logic                 pop;

   assign diff = {req_bus.query_shift[DIST_W-1], req_bus.query_shift}
               - {req_bus.candidate_shift[DIST_W-1], req_bus.candidate_shift};
   assign diff_abs = diff[DIST_W] ? (-diff) : diff;

   always_comb begin
      cand.distance = shift_mode_ff ? diff_abs[DIST_W-1:0] : req_bus.separation;
      cand.idx = req_bus.candidate_index;
      cand.keep = (req_bus.candidate_index != req_bus.query_index)
                && ({{(NUCLEI_W-IDX_W){1'b0}}, req_bus.candidate_index}
                    < NUCLEI_W'(MAX_NUCLEI));
      cand.last = req_bus.final_candidate;
      cand.query = req_bus.query_index;
   end

   assign req_bus.ready = (count_ff != (QPW+1)'(QUEUE_DEPTH));
   assign push = req_bus.valid && req_bus.ready;
   assign pop = queue_pop && (count_ff != '0);

   assign queue_head.valid = (count_ff != '0);
   assign queue_head.cand = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QPW+1)'(push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_mode_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            shift_mode_ff <= csr_write_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cand;
      end
   end

endmodule

### rtl/knn_back.sv
// Back end: sorted insertion list, index-ordered gather and result output register.
module knn_back
   import knn_pkg::*;
#(
   parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  knn_queue_type queue_head,
   output logic          queue_pop,
   knn_rsp_if.source     rsp_bus
);

   localparam int K = MAX_NEIGHBOURS;
   localparam int CW = $clog2(K + 1);

   typedef enum logic [2:0] {
      ST_RUN    = 3'b001,
      ST_GATHER = 3'b010,
      ST_EMIT   = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [DIST_W-1:0] dist_ff [K];
   logic [DIST_W-1:0] dist_in [K];
   logic [IDX_W-1:0]  didx_ff [K];
   logic [IDX_W-1:0]  didx_in [K];
   logic [CW-1:0]     dcount_ff, dcount_in;
   logic [IDX_W-1:0]  sel_ff [K];
   logic [IDX_W-1:0]  sel_in [K];
   logic [CW-1:0]     scount_ff, scount_in;
   logic [IDX_W-1:0]  query_ff, query_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_nvalid_ff, rsp_nvalid_in;
   logic              rsp_final_ff, rsp_final_in;
   logic              out_free;
   logic              load;
   logic [K-1:0]      dless;
   logic [K-1:0]      sless;
   logic              dup;
   logic [IDX_W-1:0]  head_idx;
   knn_cand_type      cand;

   assign cand = queue_head.cand;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign queue_pop = (state_ff == ST_RUN) && queue_head.valid;
   assign head_idx = didx_ff[0];

   always_comb begin
      for (int j = 0; j < K; j++) begin
         dless[j] = (CW'(j) < dcount_ff)
                  && !((cand.distance < dist_ff[j])
                       || ((cand.distance == dist_ff[j]) && (cand.idx < didx_ff[j])));
         sless[j] = (CW'(j) < scount_ff) && (sel_ff[j] < head_idx);
      end
      dup = 1'b0;
      for (int j = 0; j < K; j++) begin
         if ((CW'(j) < scount_ff) && (sel_ff[j] == head_idx)) begin
            dup = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      dist_in = dist_ff;
      didx_in = didx_ff;
      dcount_in = dcount_ff;
      sel_in = sel_ff;
      scount_in = scount_ff;
      query_in = query_ff;
      load = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_nvalid_in = rsp_nvalid_ff;
      rsp_final_in = rsp_final_ff;
      case (state_ff)
         ST_RUN: begin
            if (queue_head.valid) begin
               if (cand.keep && !((dcount_ff == CW'(K)) && dless[K-1])) begin
                  for (int j = 0; j < K; j++) begin
                     if (!dless[j]) begin
                        if (j == 0) begin
                           dist_in[j] = cand.distance;
                           didx_in[j] = cand.idx;
                        end else if (dless[j-1]) begin
                           dist_in[j] = cand.distance;
                           didx_in[j] = cand.idx;
                        end else begin
                           dist_in[j] = dist_ff[j-1];
                           didx_in[j] = didx_ff[j-1];
                        end
                     end
                  end
                  if (dcount_ff != CW'(K)) begin
                     dcount_in = dcount_ff + 1'b1;
                  end
               end
               if (cand.last) begin
                  query_in = cand.query;
                  state_in = ST_GATHER;
               end
            end
         end
         ST_GATHER: begin
            if (dcount_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               for (int j = 0; j < K - 1; j++) begin
                  dist_in[j] = dist_ff[j+1];
                  didx_in[j] = didx_ff[j+1];
               end
               dcount_in = dcount_ff - 1'b1;
               if ((head_idx > query_ff) && !dup) begin
                  for (int j = 0; j < K; j++) begin
                     if (!sless[j]) begin
                        if (j == 0) begin
                           sel_in[j] = head_idx;
                        end else if (sless[j-1]) begin
                           sel_in[j] = head_idx;
                        end else begin
                           sel_in[j] = sel_ff[j-1];
                        end
                     end
                  end
                  scount_in = scount_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               if (scount_ff == '0) begin
                  rsp_index_in = '0;
                  rsp_nvalid_in = 1'b0;
                  rsp_final_in = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  rsp_index_in = sel_ff[0];
                  rsp_nvalid_in = 1'b1;
                  rsp_final_in = (scount_ff == CW'(1));
                  for (int j = 0; j < K - 1; j++) begin
                     sel_in[j] = sel_ff[j+1];
                  end
                  scount_in = scount_ff - 1'b1;
                  if (scount_ff == CW'(1)) begin
                     state_in = ST_RUN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         dcount_ff <= '0;
         scount_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dcount_ff <= dcount_in;
         scount_ff <= scount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      didx_ff <= didx_in;
      sel_ff <= sel_in;
      query_ff <= query_in;
      rsp_index_ff <= rsp_index_in;
      rsp_nvalid_ff <= rsp_nvalid_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.neighbour_index = rsp_index_ff;
   assign rsp_bus.neighbour_valid = rsp_nvalid_ff;
   assign rsp_bus.final_result = rsp_final_ff;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the k-nearest-neighbour selector, with its scoreboard class.
import knn_pkg::*;

typedef struct packed {
   logic [IDX_W-1:0] index;
   logic             valid;
   logic             last;
} neighbour_result_type;

class neighbour_tracker;
   localparam int KEPT_DEPTH = MAX_NEIGHBOURS_DEF;

   bit                   shift_mode;
   logic [DIST_W-1:0]    ranked_dist [KEPT_DEPTH];
   logic [IDX_W-1:0]     ranked_index [KEPT_DEPTH];
   int                   ranked_count;
   neighbour_result_type expected_neighbours [$];
   int                   mismatches;
   int                   candidates_taken;
   int                   results_checked;
   int                   empty_queries;

   function bit ranks_ahead(logic [DIST_W-1:0] d1, logic [IDX_W-1:0] i1,
                            logic [DIST_W-1:0] d2, logic [IDX_W-1:0] i2);
      return (d1 < d2) || (d1 == d2 && i1 < i2);
   endfunction

   function void rank_candidate(logic [DIST_W-1:0] distance, logic [IDX_W-1:0] idx);
      int pos;
      pos = ranked_count;
      if (ranked_count >= KEPT_DEPTH) begin
         pos = KEPT_DEPTH - 1;
         if (!ranks_ahead(distance, idx, ranked_dist[pos], ranked_index[pos]))
            return;
      end else begin
         ranked_count++;
      end
      while (pos > 0 && ranks_ahead(distance, idx, ranked_dist[pos-1], ranked_index[pos-1]))
      begin
         ranked_dist[pos] = ranked_dist[pos-1];
         ranked_index[pos] = ranked_index[pos-1];
         pos--;
      end
      ranked_dist[pos] = distance;
      ranked_index[pos] = idx;
   endfunction

   function void take_candidate(logic [IDX_W-1:0] query, logic [IDX_W-1:0] cand,
                                logic [DIST_W-1:0] separation,
                                logic signed [DIST_W-1:0] query_shift,
                                logic signed [DIST_W-1:0] cand_shift, logic is_final);
      int                   diff;
      logic [DIST_W-1:0]    distance;
      logic [IDX_W-1:0]     chosen [KEPT_DEPTH];
      int                   n_chosen;
      int                   m;
      bit                   seen;
      neighbour_result_type res;
      candidates_taken++;
      if (cand != query) begin
         if (shift_mode) begin
            diff = int'(query_shift) - int'(cand_shift);
            if (diff < 0)
               diff = -diff;
            distance = diff[DIST_W-1:0];
         end else begin
            distance = separation;
         end
         rank_candidate(distance, cand);
      end
      if (!is_final)
         return;
      n_chosen = 0;
      for (int k = 0; k < ranked_count; k++) begin
         if (ranked_index[k] <= query)
            continue;
         seen = 0;
         for (int j = 0; j < n_chosen; j++)
            if (chosen[j] == ranked_index[k])
               seen = 1;
         if (seen)
            continue;
         m = n_chosen;
         while (m > 0 && chosen[m-1] > ranked_index[k]) begin
            chosen[m] = chosen[m-1];
            m--;
         end
         chosen[m] = ranked_index[k];
         n_chosen++;
      end
      ranked_count = 0;
      if (n_chosen == 0) begin
         empty_queries++;
         res = '{index: '0, valid: 1'b0, last: 1'b1};
         expected_neighbours = {expected_neighbours, res};
      end
      for (int k = 0; k < n_chosen; k++) begin
         res = '{index: chosen[k], valid: 1'b1, last: (k == n_chosen - 1)};
         expected_neighbours = {expected_neighbours, res};
      end
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task check_neighbour(logic [IDX_W-1:0] index, logic valid, logic last);
      neighbour_result_type want;
      results_checked++;
      if (expected_neighbours.size() == 0) begin
         report($sformatf("result index %0d valid %0b last %0b with nothing expected",
                          index, valid, last));
      end else begin
         want = expected_neighbours.pop_front();
         if (index !== want.index)
            report($sformatf("result %0d: neighbour_index %0d, expected %0d",
                             results_checked, index, want.index));
         if (valid !== want.valid)
            report($sformatf("result %0d: neighbour_valid %0b, expected %0b",
                             results_checked, valid, want.valid));
         if (last !== want.last)
            report($sformatf("result %0d: final_result %0b, expected %0b",
                             results_checked, last, want.last));
      end
   endtask
endclass

module testbench;
   localparam bit RANK_BY_SEPARATION = 1'b0;
   localparam bit RANK_BY_SHIFT = 1'b1;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 60;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   cycle_count;

   knn_req_if req_bus ();
   knn_rsp_if rsp_bus ();

   neighbour_tracker tracker = new;

   k_nearest_neighbour_select uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         tracker.take_candidate(req_bus.query_index, req_bus.candidate_index,
                                req_bus.separation, req_bus.query_shift,
                                req_bus.candidate_shift, req_bus.final_candidate);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_neighbour(rsp_bus.neighbour_index, rsp_bus.neighbour_valid,
                                 rsp_bus.final_result);
   end

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_candidate(logic [IDX_W-1:0] query, logic [IDX_W-1:0] cand,
                                 logic [DIST_W-1:0] separation,
                                 logic signed [DIST_W-1:0] query_shift,
                                 logic signed [DIST_W-1:0] cand_shift, logic is_final);
      int gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.query_index <= query;
      req_bus.candidate_index <= cand;
      req_bus.separation <= separation;
      req_bus.query_shift <= query_shift;
      req_bus.candidate_shift <= cand_shift;
      req_bus.final_candidate <= is_final;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (tracker.expected_neighbours.size() != 0)
         @(negedge clock);
   endtask

   task write_shift_mode(bit mode);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.shift_mode = mode;
   endtask

   function automatic logic signed [DIST_W-1:0] pick_shift(bit tight);
      logic signed [DIST_W-1:0] v;
      if (tight) begin
         v = DIST_W'(int'($urandom_range(15)) - 8);
      end else begin
         v = DIST_W'($urandom());
      end
      return v;
   endfunction

   task automatic send_random_run(output int sent);
      logic [IDX_W-1:0]  query;
      logic [IDX_W-1:0]  cand;
      logic [IDX_W-1:0]  prev_cand;
      logic [IDX_W-1:0]  item_query;
      logic [DIST_W-1:0] separation;
      int                run_len;
      int                pick;
      bit                tight;
      pick = $urandom_range(99);
      if (pick < 10)
         query = IDX_W'($urandom_range(15));
      else if (pick < 20)
         query = IDX_W'($urandom_range(4095, 4080));
      else
         query = IDX_W'($urandom());
      run_len = ($urandom_range(99) < 85) ? $urandom_range(20, 1) : $urandom_range(40, 17);
      tight = 1'($urandom_range(1));
      prev_cand = IDX_W'($urandom());
      for (int i = 0; i < run_len; i++) begin
         pick = $urandom_range(99);
         if (pick < 8)
            cand = query;
         else if (pick < 20 && i > 0)
            cand = prev_cand;
         else if (pick < 45)
            cand = IDX_W'(query + $urandom_range(16) - 8);
         else
            cand = IDX_W'($urandom());
         pick = $urandom_range(99);
         if (tight)
            separation = DIST_W'($urandom_range(7));
         else if (pick < 5)
            separation = '1;
         else if (pick < 10)
            separation = '0;
         else
            separation = DIST_W'($urandom());
         item_query = ($urandom_range(99) < 3) ? IDX_W'($urandom()) : query;
         send_candidate(item_query, cand, separation, pick_shift(tight), pick_shift(tight),
                        i == run_len - 1);
         prev_cand = cand;
      end
      sent = run_len;
   endtask

   initial begin
      int send_pcts [5];
      int recv_pcts [5];
      bit modes [5];
      int phase_items;
      int run_items;
      int run_no;
      send_pcts = '{0, 62, 0, 21, 0};
      recv_pcts = '{0, 0, 62, 21, 0};
      modes = '{RANK_BY_SEPARATION, RANK_BY_SHIFT, RANK_BY_SHIFT,
                RANK_BY_SEPARATION, RANK_BY_SHIFT};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.query_index = '0;
      req_bus.candidate_index = '0;
      req_bus.separation = '0;
      req_bus.query_shift = '0;
      req_bus.candidate_shift = '0;
      req_bus.final_candidate = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_shift_mode(RANK_BY_SEPARATION);
      // Self match, extreme separations, a distance tie and a repeated index.
      send_candidate(12'd0, 12'd0, 24'd5, '0, '0, 1'b0);
      send_candidate(12'd0, 12'd4095, 24'hFFFFFF, '0, '0, 1'b0);
      send_candidate(12'd0, 12'd5, 24'd0, '0, '0, 1'b0);
      send_candidate(12'd0, 12'd7, 24'd0, '0, '0, 1'b0);
      send_candidate(12'd0, 12'd5, 24'd10, '0, '0, 1'b0);
      send_candidate(12'd0, 12'd9, 24'd100, '0, '0, 1'b1);
      // The highest query index leaves nothing that qualifies.
      send_candidate(12'd4095, 12'd100, 24'd3, '0, '0, 1'b1);
      // The query index changes within the run.
      send_candidate(12'd10, 12'd20, 24'd50, '0, '0, 1'b0);
      send_candidate(12'd30, 12'd10, 24'd40, '0, '0, 1'b0);
      send_candidate(12'd15, 12'd15, 24'd0, '0, '0, 1'b1);

      write_shift_mode(RANK_BY_SHIFT);
      // Opposite extreme shifts give the largest distance in both directions.
      send_candidate(12'd1, 12'd2, 24'd0, 24'sh800000, 24'sh7FFFFF, 1'b0);
      send_candidate(12'd1, 12'd3, 24'd0, 24'sh7FFFFF, 24'sh800000, 1'b0);
      send_candidate(12'd1, 12'd4, 24'hFFFFFF, '0, '0, 1'b0);
      send_candidate(12'd1, 12'd0, 24'd1, 24'sd5, 24'sd5, 1'b1);
      // A lone final candidate equal to the query.
      send_candidate(12'd50, 12'd50, 24'd1, 24'sd3, -24'sd3, 1'b1);

      for (int phase = 0; phase < 5; phase++) begin
         write_shift_mode(modes[phase]);
         send_idle_pct = send_pcts[phase];
         recv_stall_pct = recv_pcts[phase];
         phase_items = 0;
         run_no = 0;
         while (phase_items < PHASE_ITEMS) begin
            send_random_run(run_items);
            phase_items += run_items;
            run_no++;
            if (run_no == 2 || $urandom_range(9) == 0)
               drain_results();
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("summary: %0d candidates, %0d results checked, %0d queries with no neighbour",
               tracker.candidates_taken, tracker.results_checked, tracker.empty_queries);
      $display("summary: both ranking modes, four stall mixes, %0d mismatches",
               tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule
